>>> rtl/core/wsfr_pkg.sv
package wsfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned KEY_W    = 32;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_LEN16   = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } wsfr_phase_t;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_PONG  = 2'd1,
        EV_CLOSE = 2'd2,
        EV_DROP  = 2'd3
    } wsfr_event_t;

    localparam logic [OPCODE_W-1:0] OP_TEXT   = 4'h1;
    localparam logic [OPCODE_W-1:0] OP_BINARY = 4'h2;
    localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        logic              valid;
        wsfr_event_t       kind;
        logic [BYTE_W-1:0] data;
        logic              binary;
        logic              last;
    } wsfr_result_t;

endpackage

>>> rtl/core/wsfr_parser.sv
module wsfr_parser
    import wsfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    output wsfr_result_t      result
);

    wsfr_phase_t         phase_reg, phase_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic                mask_en_reg, mask_en_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [1:0]          hdr_cnt_reg, hdr_cnt_next;
    logic [BYTE_W-1:0]   len_hi_reg, len_hi_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [LEN_W-1:0]    pay_cnt_reg, pay_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            mask_en_reg <= 1'b0;
            length_reg  <= '0;
            hdr_cnt_reg <= '0;
            len_hi_reg  <= '0;
            key_reg     <= '0;
            pay_cnt_reg <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_en_reg <= mask_en_next;
            length_reg  <= length_next;
            hdr_cnt_reg <= hdr_cnt_next;
            len_hi_reg  <= len_hi_next;
            key_reg     <= key_next;
            pay_cnt_reg <= pay_cnt_next;
        end
    end

    always_comb begin
        logic              start;
        logic              finish;
        logic [LEN_W-1:0]  new_len;
        logic [LEN_W-1:0]  cnt_inc;
        logic [BYTE_W-1:0] key_byte;
        logic              last;

        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_en_next = mask_en_reg;
        length_next  = length_reg;
        hdr_cnt_next = hdr_cnt_reg;
        len_hi_next  = len_hi_reg;
        key_next     = key_reg;
        pay_cnt_next = pay_cnt_reg;
        result       = '{valid: 1'b0, kind: EV_DATA, data: '0, binary: 1'b0, last: 1'b0};
        start        = 1'b0;
        finish       = 1'b0;
        new_len      = length_reg;
        cnt_inc      = pay_cnt_reg + LEN_W'(1);
        key_byte     = key_reg[{pay_cnt_reg[1:0], 3'b000} +: BYTE_W];
        last         = (cnt_inc >= length_reg);

        case (phase_reg)
            PH_HDR1: begin
                mask_en_next = rx_byte[7];
                new_len      = LEN_W'(rx_byte[6:0]);
                length_next  = new_len;
                if (rx_byte[6:0] == LEN7_EXT64) begin
                    // 64-bit lengths are not supported: drop the link
                    phase_next = PH_HDR0;
                    result     = '{valid: 1'b1, kind: EV_DROP, data: '0,
                                   binary: 1'b0, last: 1'b0};
                end else begin
                    hdr_cnt_next = '0;
                    if (rx_byte[6:0] == LEN7_EXT16) begin
                        phase_next = PH_LEN16;
                    end else if (rx_byte[7]) begin
                        phase_next = PH_MASK;
                    end else begin
                        start = 1'b1;
                    end
                end
            end
            PH_LEN16: begin
                if (hdr_cnt_reg == 2'd0) begin
                    len_hi_next  = rx_byte;
                    hdr_cnt_next = 2'd1;
                end else begin
                    new_len      = {len_hi_reg, rx_byte};
                    length_next  = new_len;
                    hdr_cnt_next = '0;
                    if (mask_en_reg) begin
                        phase_next = PH_MASK;
                    end else begin
                        start = 1'b1;
                    end
                end
            end
            PH_MASK: begin
                key_next[{hdr_cnt_reg, 3'b000} +: BYTE_W] = rx_byte;
                if (hdr_cnt_reg != 2'd3) begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end else begin
                    hdr_cnt_next = '0;
                    start        = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                pay_cnt_next = cnt_inc;
                if (opcode_reg == OP_TEXT || opcode_reg == OP_BINARY) begin
                    if (last) begin
                        phase_next = PH_HDR0;
                    end
                    result = '{valid: 1'b1, kind: EV_DATA,
                               data: mask_en_reg ? (rx_byte ^ key_byte) : rx_byte,
                               binary: (opcode_reg == OP_BINARY), last: last};
                end else if (last) begin
                    finish = 1'b1;
                end
            end
            default: begin
                // first header byte; FIN and RSV bits ignored
                opcode_next = rx_byte[OPCODE_W-1:0];
                phase_next  = PH_HDR1;
            end
        endcase

        // header complete: enter payload or close out an empty frame
        if (start) begin
            pay_cnt_next = '0;
            if (new_len != '0) begin
                phase_next = PH_PAYLOAD;
            end else begin
                finish = 1'b1;
            end
        end

        if (finish) begin
            phase_next = PH_HDR0;
            if (opcode_reg == OP_CLOSE) begin
                result = '{valid: 1'b1, kind: EV_CLOSE, data: '0, binary: 1'b0, last: 1'b0};
            end else if (opcode_reg == OP_PING) begin
                result = '{valid: 1'b1, kind: EV_PONG, data: '0, binary: 1'b0, last: 1'b0};
            end
        end
    end

endmodule

>>> rtl/core/websocket_frame_receiver.sv
// Channel | Handshake        | Payload ports                                           | Item
// --------+------------------+---------------------------------------------------------+------
// input   | s_valid, s_ready | s_rx_byte                                               | byte
// result  | m_valid, m_ready | m_event_kind, m_data_byte, m_is_binary, m_last_in_frame | event
//
// One byte is accepted per cycle while s_ready is high. It waits in the input register until the
// result register is free; then the parser steps on it and loads its event, if any, raising m_valid.
// Synchronous active-low reset returns the parser to the first header byte, both regs empty.
// While a result waits with m_ready low, hold the byte in the input register whatever it
// would produce; s_ready drops once that register is full, and both advance in the cycle the
// result is taken.
module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_event_kind,
    output logic [BYTE_W-1:0] m_data_byte,
    output logic              m_is_binary,
    output logic              m_last_in_frame
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic              out_valid_reg;
    wsfr_event_t       out_kind_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_bin_reg;
    logic              out_last_reg;

    wsfr_result_t      result;
    logic              out_free;
    logic              advance;

    // result register can take a new event when empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    // advance the held byte through the parser
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    wsfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && result.valid;
        end
    end

    // capture payload only when a new event is written
    always_ff @(posedge aclk) begin
        if (advance && result.valid && out_free) begin
            out_kind_reg <= result.kind;
            out_data_reg <= result.data;
            out_bin_reg  <= result.binary;
            out_last_reg <= result.last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_kind_reg;
    assign m_data_byte     = out_data_reg;
    assign m_is_binary     = out_bin_reg;
    assign m_last_in_frame = out_last_reg;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb
    import wsfr_pkg::*;
();

    // One queued byte; row points into the directed table, or is -1 for random bytes.
    typedef struct {
        logic [BYTE_W-1:0] rx;
        int                row;
    } queued_byte_t;

    // One row of the directed table. Rows with fixed_exp set carry their own expectation.
    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                fixed_exp;
        bit                has_event;
        wsfr_result_t      ev;
    } stim_row_t;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte       = '0;
    int                s_row           = -1;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [1:0]        m_event_kind;
    logic [BYTE_W-1:0] m_data_byte;
    logic              m_is_binary;
    logic              m_last_in_frame;

    websocket_frame_receiver DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_data_byte     (m_data_byte),
        .m_is_binary     (m_is_binary),
        .m_last_in_frame (m_last_in_frame)
    );

    // Parser copy: mirrors the header/payload state machine of the block.
    wsfr_phase_t         rx_phase   = PH_HDR0;
    logic [OPCODE_W-1:0] rx_opcode  = '0;
    logic                rx_masked  = 1'b0;
    logic [LEN_W-1:0]    rx_len     = '0;
    logic [1:0]          rx_hdr_cnt = '0;
    logic [BYTE_W-1:0]   rx_len_hi  = '0;
    logic [KEY_W-1:0]    rx_key     = '0;
    logic [LEN_W-1:0]    rx_pay_cnt = '0;

    stim_row_t    directed_rows[$];
    queued_byte_t tx_bytes[$];
    wsfr_result_t expected_events[$];

    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int sink_hold_left = 0;

    int mismatch_count = 0;
    int bytes_accepted = 0;
    int results_seen   = 0;
    int kind_seen[4]   = '{0, 0, 0, 0};

    // Clock: 20 ns period.
    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Frame done: ping asks for a pong, close for an echo; everything returns to the header.
    function automatic bit close_frame(output wsfr_result_t ev);
        ev       = '0;
        ev.valid = 1'b1;
        rx_phase = PH_HDR0;
        if (rx_opcode == OP_CLOSE) begin
            ev.kind = EV_CLOSE;
            return 1'b1;
        end
        if (rx_opcode == OP_PING) begin
            ev.kind = EV_PONG;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Header done: enter the payload, or finish an empty frame right here.
    function automatic bit enter_payload(output wsfr_result_t ev);
        ev         = '0;
        rx_pay_cnt = '0;
        if (rx_len != '0) begin
            rx_phase = PH_PAYLOAD;
            return 1'b0;
        end
        return close_frame(ev);
    endfunction

    // Advance the parser copy by one received byte; return 1 when the byte yields an event.
    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output wsfr_result_t ev);
        logic [BYTE_W-1:0] data;
        bit                fin;
        ev       = '0;
        ev.valid = 1'b1;
        case (rx_phase)
            PH_HDR1: begin
                rx_masked = b[7];
                rx_len    = {9'd0, b[6:0]};
                if (b[6:0] == LEN7_EXT64) begin
                    rx_phase = PH_HDR0;
                    ev.kind  = EV_DROP;
                    return 1'b1;
                end
                rx_hdr_cnt = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    rx_phase = PH_LEN16;
                    return 1'b0;
                end
                if (rx_masked) begin
                    rx_phase = PH_MASK;
                    return 1'b0;
                end
                return enter_payload(ev);
            end
            PH_LEN16: begin
                if (rx_hdr_cnt == 2'd0) begin
                    rx_len_hi  = b;
                    rx_hdr_cnt = 2'd1;
                    return 1'b0;
                end
                rx_len     = {rx_len_hi, b};
                rx_hdr_cnt = '0;
                if (rx_masked) begin
                    rx_phase = PH_MASK;
                    return 1'b0;
                end
                return enter_payload(ev);
            end
            PH_MASK: begin
                rx_key[{rx_hdr_cnt, 3'b000} +: 8] = b;
                if (rx_hdr_cnt < 2'd3) begin
                    rx_hdr_cnt = rx_hdr_cnt + 2'd1;
                    return 1'b0;
                end
                rx_hdr_cnt = '0;
                return enter_payload(ev);
            end
            PH_PAYLOAD: begin
                data = rx_masked ? (b ^ rx_key[{rx_pay_cnt[1:0], 3'b000} +: 8]) : b;
                rx_pay_cnt = rx_pay_cnt + 16'd1;
                fin = (rx_pay_cnt >= rx_len);
                if (rx_opcode == OP_TEXT || rx_opcode == OP_BINARY) begin
                    if (fin) begin
                        rx_phase = PH_HDR0;
                    end
                    ev.kind   = EV_DATA;
                    ev.data   = data;
                    ev.binary = (rx_opcode == OP_BINARY);
                    ev.last   = fin;
                    return 1'b1;
                end
                if (fin) begin
                    return close_frame(ev);
                end
                return 1'b0;
            end
            default: begin
                rx_opcode = b[3:0];
                rx_phase  = PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void add_row(input logic [BYTE_W-1:0] rx, input bit fixed_exp,
                                    input bit has_event, input wsfr_event_t kind,
                                    input logic [BYTE_W-1:0] data, input bit bin,
                                    input bit last);
        stim_row_t row;
        row.rx        = rx;
        row.fixed_exp = fixed_exp;
        row.has_event = has_event;
        row.ev        = '0;
        row.ev.valid  = 1'b1;
        row.ev.kind   = kind;
        row.ev.data   = data;
        row.ev.binary = bin;
        row.ev.last   = last;
        directed_rows.push_back(row);
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] rx, input int row);
        queued_byte_t qb;
        qb.rx  = rx;
        qb.row = row;
        tx_bytes.push_back(qb);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    // Queue one random frame: mostly well formed, some noise, 64-bit lengths and short frames.
    task automatic queue_random_frame();
        int unsigned       pick;
        int unsigned       len;
        int unsigned       sent_len;
        int unsigned       i;
        logic [3:0]        op;
        logic [KEY_W-1:0]  key;
        bit                masked;
        bit                ext;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // noise: the parser reads it as headers or payload, whatever comes
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), -1);
            return;
        end
        if (pick < 12) begin
            push_byte(8'($urandom_range(255)), -1);
            push_byte({1'($urandom_range(1)), LEN7_EXT64}, -1);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)), -1);
            return;
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
            op = OP_TEXT;
        end else if (pick < 65) begin
            op = OP_BINARY;
        end else if (pick < 75) begin
            op = OP_PING;
        end else if (pick < 83) begin
            op = OP_CLOSE;
        end else begin
            do begin
                op = 4'($urandom_range(15));
            end while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE || op == OP_PING);
        end
        // upper nibble carries FIN and RSV, which the parser ignores
        push_byte({4'($urandom_range(15)), op}, -1);
        pick = $urandom_range(99);
        ext  = (pick >= 72);
        if (pick < 60) begin
            len = $urandom_range(0, 8);
        end else if (pick < 72) begin
            len = $urandom_range(9, 125);
        end else if (pick < 95) begin
            len = $urandom_range(0, 300);
        end else begin
            len = $urandom_range(0, 700);
        end
        masked = ($urandom_range(99) < 75);
        push_byte({masked, ext ? LEN7_EXT16 : 7'(len)}, -1);
        if (ext) begin
            push_byte(len[15:8], -1);
            push_byte(len[7:0], -1);
        end
        if (masked) begin
            key = $urandom;
            for (i = 0; i < 4; i++) push_byte(key[8*i +: 8], -1);
        end
        sent_len = len;
        if (len > 0 && $urandom_range(99) < 6) begin
            // cut the frame short: the next header lands in the payload
            sent_len = $urandom_range(0, len - 1);
        end
        for (i = 0; i < sent_len; i++) push_byte(8'($urandom_range(255)), -1);
    endtask

    // Offer queued bytes; hold each one until it is taken, idle at random in between.
    task automatic send_queued();
        queued_byte_t qb;
        bit           done;
        done = 1'b0;
        while (!done) begin
            @(posedge aclk);
            if (!(s_valid && !s_ready)) begin
                if (tx_bytes.size() == 0) begin
                    s_valid <= 1'b0;
                    done = 1'b1;
                end else if ($urandom_range(99) < src_idle_pct) begin
                    s_valid <= 1'b0;
                end else begin
                    qb = tx_bytes.pop_front();
                    s_valid   <= 1'b1;
                    s_rx_byte <= qb.rx;
                    s_row     <= qb.row;
                end
            end
        end
    endtask

    task automatic wait_for_results();
        while (expected_events.size() != 0) @(posedge aclk);
    endtask

    // Result side: idle at random, or hold off entirely while a long stall is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold_left > 0) begin
                m_ready <= 1'b0;
                sink_hold_left = sink_hold_left - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Accepted byte: advance the parser copy and queue the event it causes.
    always @(posedge aclk) begin : accept_monitor
        wsfr_result_t ev;
        bit           has_event;
        if (aresetn && s_valid && s_ready) begin
            has_event = parse_rx_byte(s_rx_byte, ev);
            // typed rows override the parser copy; the copy still advances
            if (s_row >= 0 && directed_rows[s_row].fixed_exp) begin
                has_event = directed_rows[s_row].has_event;
                ev        = directed_rows[s_row].ev;
            end
            if (has_event) begin
                expected_events.push_back(ev);
            end
            bytes_accepted++;
        end
    end

    // Accepted result: compare against the oldest expected event.
    always @(posedge aclk) begin : result_monitor
        wsfr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            kind_seen[m_event_kind]++;
            if (expected_events.size() == 0) begin
                note_mismatch($sformatf("unexpected result kind=%0d data=%02h bin=%0b last=%0b",
                                        m_event_kind, m_data_byte, m_is_binary,
                                        m_last_in_frame));
            end else begin
                want = expected_events.pop_front();
                if (m_event_kind !== want.kind || m_data_byte !== want.data ||
                    m_is_binary !== want.binary || m_last_in_frame !== want.last) begin
                    note_mismatch($sformatf({"result %0d: expected kind=%0d data=%02h ",
                                             "bin=%0b last=%0b, got kind=%0d data=%02h ",
                                             "bin=%0b last=%0b"},
                        results_seen, want.kind, want.data, want.binary, want.last,
                        m_event_kind, m_data_byte, m_is_binary, m_last_in_frame));
                end
            end
        end
    end

    initial begin : stimulus
        int src_pct[3];
        int sink_pct[3];
        int p;
        int h;
        int r;
        src_pct  = '{24, 62, 0};
        sink_pct = '{62, 24, 0};

        // Directed table: byte, typed?, event?, kind, data, binary, last.
        // Reserved opcode with FIN and RSV set, then a 64-bit length: drop.
        add_row(8'hFF, 1, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'hFF, 1, 1, EV_DROP,  8'h00, 0, 0);
        // Empty unmasked ping: pong on its length byte.
        add_row(8'h89, 1, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h00, 1, 1, EV_PONG,  8'h00, 0, 0);
        // Empty close: echo and disconnect on its length byte.
        add_row(8'h88, 1, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h00, 1, 1, EV_CLOSE, 8'h00, 0, 0);
        // Unmasked text, FIN clear, payload bytes at both extremes pass unchanged.
        add_row(8'h01, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h02, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h00, 1, 1, EV_DATA,  8'h00, 0, 0);
        add_row(8'hFF, 1, 1, EV_DATA,  8'hFF, 0, 1);
        // Masked binary with a 16-bit length of one.
        add_row(8'h82, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'hFE, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h00, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h01, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h12, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h34, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h56, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h78, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'hAB, 0, 0, EV_DATA,  8'h00, 0, 0);
        // Continuation with RSV bits: payload dropped, no event.
        add_row(8'h70, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h01, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h77, 0, 0, EV_DATA,  8'h00, 0, 0);
        // Ping with a two-byte payload: pong on the last payload byte.
        add_row(8'h89, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h02, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h11, 0, 0, EV_DATA,  8'h00, 0, 0);
        add_row(8'h22, 0, 0, EV_DATA,  8'h00, 0, 0);

        // Hold reset, then release it for good.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table under the first idling pattern.
        src_idle_pct  = src_pct[0];
        sink_idle_pct = sink_pct[0];
        for (r = 0; r < directed_rows.size(); r++) push_byte(directed_rows[r].rx, r);
        send_queued();
        wait_for_results();

        // Random frames: three idling patterns, each split in two with a full drain between.
        for (p = 0; p < 3; p++) begin
            src_idle_pct  = src_pct[p];
            sink_idle_pct = sink_pct[p];
            if (p == 2) begin
                // stall the result side long enough to back up the input
                sink_hold_left = 400;
            end
            for (h = 0; h < 2; h++) begin
                while (tx_bytes.size() < 175) queue_random_frame();
                send_queued();
                wait_for_results();
            end
        end

        // Let any trailing result show up before the verdict.
        repeat (8) @(posedge aclk);
        if (expected_events.size() != 0) begin
            note_mismatch($sformatf("%0d expected results never arrived",
                                    expected_events.size()));
        end

        $display("Run covered %0d bytes in and %0d results out (%0d mismatching).",
                 bytes_accepted, results_seen, mismatch_count);
        $display("Events: %0d payload bytes, %0d pongs, %0d close echoes, %0d length drops.",
                 kind_seen[EV_DATA], kind_seen[EV_PONG], kind_seen[EV_CLOSE],
                 kind_seen[EV_DROP]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
